>>> sv/esc_pkg.sv
`default_nettype none

package esc_pkg;

  // Built sizes
  localparam int PAGES      = 16;
  localparam int FRAMES     = 8;
  localparam int SWAP_SLOTS = 16;

  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int SLOT_W  = $clog2(SWAP_SLOTS);
  localparam int CFG_W   = 4;
  localparam int TOT_W   = 16;

  localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = CFG_W'(FRAMES);

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [SLOT_W-1:0]  evicted_slot;
    logic               loaded_from_swap;
    logic [SLOT_W-1:0]  loaded_slot;
    logic [TOT_W-1:0]   miss_total;
    logic [TOT_W-1:0]   access_total;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic access;
    logic scan;
    logic evict;
    logic slot;
    logic install;
    logic emit;
  } esc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic fill;
    logic found;
    logic slot_free;
    logic slot_last;
    logic out_free;
  } esc_sts_t;

endpackage

`default_nettype wire

>>> sv/enhanced_second_chance_pager.sv
// Enhanced second-chance page replacement with a swap area.
//
// Input channel: one page access (op, page) per transfer, on in_valid_i with
// in_stall_o from the block. Output channel: one result per access (hit,
// frame, eviction and swap-load details, running totals) on out_valid_o,
// with out_stall_i from the receiver. cfg_we_i writes active_frames from
// cfg_wdata_i; write it only while no access is in progress.
//
// One access is processed at a time. A hit goes straight to its result,
// and a fill of a free frame first installs the page. A replacement
// walks the clock one frame per cycle, over up to 3 x active_frames + 1
// frames, then probes the swap slots one per cycle, up to 16 slots. The
// next access is taken on the cycle after the result is loaded into the
// output register.
//
// Reset empties all frames and swap slots, clears the totals and sets
// active_frames to 8. While the receiver stalls, the output register holds
// its result; one further access may complete and waits until it frees.
`default_nettype none

module enhanced_second_chance_pager (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [3:0]          cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  esc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output esc_pkg::out_item_t out_item_o
);
  import esc_pkg::*;

  esc_cmd_t cmd;
  esc_sts_t sts;

  // Sequencer
  esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Page tables, clock search, swap allocation and output register
  esc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> sv/esc_ctrl.sv
`default_nettype none

module esc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  esc_pkg::esc_sts_t sts_i,
  output esc_pkg::esc_cmd_t cmd_o
);
  import esc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ACCESS  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_EVICT   = 3'd3;
  localparam logic [2:0] S_SLOT    = 3'd4;
  localparam logic [2:0] S_INSTALL = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state_q, state_d;

  // Only one access in flight
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        if (sts_i.hit) begin
          state_d = S_FINISH;
        end else if (sts_i.fill) begin
          state_d = S_INSTALL;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_SLOT;
      end
      S_SLOT: begin
        cmd_o.slot = 1'b1;
        if (sts_i.slot_free || sts_i.slot_last) begin
          state_d = S_INSTALL;
        end
      end
      S_INSTALL: begin
        cmd_o.install = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A scan only follows a miss that found no free frame
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS && !sts_i.hit && !sts_i.fill) |=> (state_q == S_SCAN))
    else $error("scan not entered after full-frame miss");

  // Results leave only when the output register can take them
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit while output register blocked");

  // A hit goes straight to the result
  a_hit_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS && sts_i.hit) |=> (state_q == S_FINISH))
    else $error("hit did not finish directly");

endmodule

`default_nettype wire

>>> sv/esc_dpath.sv
`default_nettype none

module esc_dpath (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [3:0]          cfg_wdata_i,
  input  esc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output esc_pkg::out_item_t out_item_o,
  input  esc_pkg::esc_cmd_t  cmd_i,
  output esc_pkg::esc_sts_t  sts_o
);
  import esc_pkg::*;

  // Configuration
  logic [CFG_W-1:0] active_frames_q;
  logic [CNT_W-1:0] n_eff;

  // Current access
  logic              op_q;
  logic [PAGE_W-1:0] page_q;
  out_item_t         res_q;

  // Per-page and per-slot flags (reset) and payload (no reset)
  logic [PAGES-1:0]      resident_q;
  logic [PAGES-1:0]      ref_q;
  logic [PAGES-1:0]      dirty_q;
  logic [PAGES-1:0]      slot_valid_q;
  logic [SWAP_SLOTS-1:0] busy_q;
  logic [FRAME_W-1:0]    frame_of_q [PAGES];
  logic [SLOT_W-1:0]     slot_of_q  [PAGES];
  logic [PAGE_W-1:0]     owner_q    [FRAMES];

  // Clock and search state
  logic [CNT_W-1:0]   filled_q;
  logic [FRAME_W-1:0] hand_q;
  logic [FRAME_W-1:0] j_q;
  logic [FRAME_W-1:0] k_q;
  logic [1:0]         pass_q;
  logic [FRAME_W-1:0] f_q;
  logic [PAGE_W-1:0]  vq_q;
  logic [SLOT_W-1:0]  s_q;
  logic [TOT_W-1:0]   fault_q;
  logic [TOT_W-1:0]   access_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;

  // Combinational helpers
  logic [PAGE_W-1:0]  scan_pg;
  logic [PAGE_W-1:0]  ev_pg;
  logic               found;
  logic [CNT_W-1:0]   j_inc;
  logic [CNT_W-1:0]   k_inc;
  logic [CNT_W-1:0]   f_inc;
  logic [FRAME_W-1:0] hand_start;
  logic [SLOT_W-1:0]  ld_slot;
  out_item_t          res_acc;
  out_item_t          res_emit;

  // Frames in use, clamped to 1..FRAMES
  always_comb begin
    priority if (active_frames_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_frames_q > CFG_W'(FRAMES)) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(active_frames_q);
    end
  end

  assign scan_pg    = owner_q[j_q];
  assign ev_pg      = owner_q[f_q];
  assign found      = !ref_q[scan_pg] && (dirty_q[scan_pg] == pass_q[0]);
  assign j_inc      = {1'b0, j_q} + CNT_W'(1);
  assign k_inc      = {1'b0, k_q} + CNT_W'(1);
  assign f_inc      = {1'b0, f_q} + CNT_W'(1);
  assign hand_start = ({1'b0, hand_q} < n_eff) ? hand_q : '0;
  assign ld_slot    = slot_of_q[page_q];

  // Result as first formed on the access cycle
  always_comb begin
    res_acc       = '0;
    res_acc.hit   = resident_q[page_q];
    res_acc.frame = resident_q[page_q] ? frame_of_q[page_q] : '0;
  end

  // Result with running totals, as loaded into the output register
  always_comb begin
    res_emit              = res_q;
    res_emit.miss_total   = fault_q;
    res_emit.access_total = access_q;
  end

  // Status to controller
  always_comb begin
    sts_o           = '0;
    sts_o.hit       = resident_q[page_q];
    sts_o.fill      = (filled_q < n_eff);
    sts_o.found     = found;
    sts_o.slot_free = !busy_q[s_q];
    sts_o.slot_last = (s_q == SLOT_W'(SWAP_SLOTS - 1));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_frames_q <= ACTIVE_FRAMES_RST;
    end else if (cfg_we_i) begin
      active_frames_q <= cfg_wdata_i;
    end
  end

  // Control state: flags, hand, fill count, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident_q   <= '0;
      ref_q        <= '0;
      dirty_q      <= '0;
      slot_valid_q <= '0;
      busy_q       <= '0;
      filled_q     <= '0;
      hand_q       <= '0;
      fault_q      <= '0;
      access_q     <= '0;
    end else begin
      if (cmd_i.access) begin
        ref_q[page_q]   <= 1'b1;
        dirty_q[page_q] <= op_q;
        if (access_q != '1) begin
          access_q <= access_q + TOT_W'(1);
        end
        if (!resident_q[page_q]) begin
          if (fault_q != '1) begin
            fault_q <= fault_q + TOT_W'(1);
          end
          if (filled_q < n_eff) begin
            filled_q <= filled_q + CNT_W'(1);
          end
        end
      end
      // second pass of each round clears the reference bits it passes
      if (cmd_i.scan && !found && pass_q[0]) begin
        ref_q[scan_pg] <= 1'b0;
      end
      if (cmd_i.evict) begin
        resident_q[ev_pg]   <= 1'b0;
        slot_valid_q[ev_pg] <= 1'b0;
        hand_q <= (f_inc >= n_eff) ? '0 : f_inc[FRAME_W-1:0];
      end
      if (cmd_i.slot && !busy_q[s_q]) begin
        busy_q[s_q]        <= 1'b1;
        slot_valid_q[vq_q] <= 1'b1;
      end
      if (cmd_i.install) begin
        resident_q[page_q] <= 1'b1;
        if (slot_valid_q[page_q]) begin
          busy_q[ld_slot]      <= 1'b0;
          slot_valid_q[page_q] <= 1'b0;
        end
      end
    end
  end

  // Search control: pass, step count, frame under the hand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q    <= '0;
      k_q    <= '0;
      pass_q <= '0;
    end else if (cmd_i.access) begin
      j_q    <= hand_start;
      k_q    <= '0;
      pass_q <= '0;
    end else if (cmd_i.scan && !found) begin
      j_q <= (j_inc == n_eff) ? '0 : j_inc[FRAME_W-1:0];
      if (k_inc == n_eff) begin
        k_q    <= '0;
        pass_q <= pass_q + 2'd1;
      end else begin
        k_q <= k_inc[FRAME_W-1:0];
      end
    end
  end

  // Payload: current item, victim, tables, result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= in_item_i.op;
      page_q <= in_item_i.page;
    end
    if (cmd_i.access) begin
      res_q <= res_acc;
      f_q   <= filled_q[FRAME_W-1:0];
    end
    if (cmd_i.scan && found) begin
      f_q <= j_q;
    end
    if (cmd_i.evict) begin
      vq_q                <= ev_pg;
      s_q                 <= '0;
      res_q.evicted_valid <= 1'b1;
      res_q.evicted_page  <= ev_pg;
    end
    if (cmd_i.slot) begin
      if (!busy_q[s_q]) begin
        slot_of_q[vq_q]    <= s_q;
        res_q.evicted_slot <= s_q;
      end else begin
        s_q <= s_q + SLOT_W'(1);
      end
    end
    if (cmd_i.install) begin
      owner_q[f_q]      <= page_q;
      frame_of_q[page_q] <= f_q;
      res_q.frame       <= f_q;
      if (slot_valid_q[page_q]) begin
        res_q.loaded_from_swap <= 1'b1;
        res_q.loaded_slot      <= ld_slot;
      end
    end
    if (cmd_i.emit) begin
      out_q <= res_emit;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Faults never outnumber accesses
  a_cnt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    access_q >= fault_q)
    else $error("fault count above access count");

  // The fourth pass always finds a victim
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && pass_q == 2'd3 && k_inc == n_eff) |-> found)
    else $error("clock search ran past the fourth pass");

  // The victim frame holds a resident page
  a_victim_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> resident_q[ev_pg])
    else $error("victim page not resident");

  // A page put into swap was resident until this fault
  a_slot_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.slot && !busy_q[s_q]) |-> !resident_q[vq_q] && !slot_valid_q[vq_q])
    else $error("swap slot given to a page still resident or holding a slot");

endmodule

`default_nettype wire
